// ----- src/tsch_pkg.sv -----
`default_nettype none
package tsch_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int NUM_OBJECTS_DEF = 8;
   localparam int TIME_W = 11;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam logic [2:0] KIND_ACCEPT = 3'd0;
   localparam logic [2:0] KIND_REJECT = 3'd1;
   localparam logic [2:0] KIND_DONE = 3'd2;
   localparam logic [2:0] KIND_START = 3'd3;
   localparam logic [2:0] KIND_STOP = 3'd4;

   typedef struct packed {
      logic [1:0] opcode;
      logic [2:0] object_id;
      logic [4:0] start_hour;
      logic [5:0] start_minute;
      logic [4:0] stop_hour;
      logic [5:0] stop_minute;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
      logic [7:0] running_mask;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] object_id_out;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]        obj;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] stop;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   function automatic logic [TIME_W-1:0] minutes(input logic [4:0] h, input logic [5:0] m);
      minutes = TIME_W'(h) * TIME_W'(60) + TIME_W'(m);
   endfunction

endpackage
`default_nettype wire

// ----- src/tsch_cell.sv -----
`default_nettype none
module tsch_cell (
   input  wire logic                 clock,
   input  wire tsch_pkg::cell_ctl_type ctl,
   input  wire tsch_pkg::entry_type  load_data,
   input  wire tsch_pkg::entry_type  next_data,
   output tsch_pkg::entry_type       data
);
   tsch_pkg::entry_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule
`default_nettype wire

// ----- src/time_window_task_scheduler.sv -----
`default_nettype none
// time window task scheduler
// req channel: a command transfer happens at a clock edge with start high and
//   busy low; opcode selects add, remove, clear or tick
// csr channel: registered_mask write, always ready, take it only while idle
// rsp channel: each result shows for one cycle with rsp_valid high; the
//   receiver cannot stall, so no backpressure exists
// entries live in a row of cells; a walk shifts the row left once a cycle
//   and the entry leaving cell 0 is examined, then written back at the tail
//   unless a remove drops it, so order is kept and compaction is free
// clear goes straight from idle to the finish state for its done result; add,
//   remove and tick first walk the stored entries, one walk step per entry
// tick emits start/stop results during the walk, one per acting entry, then
//   done with last set; busy stays high until that final result is issued
// a new command is taken only in idle, after the last one has finished
// reset clears the entry count, the mask and control state; cell contents
//   are left as they are and only entries below the count are ever read
module time_window_task_scheduler #(
   parameter int MAX_TASKS = tsch_pkg::MAX_TASKS_DEF,
   parameter int NUM_OBJECTS = tsch_pkg::NUM_OBJECTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tsch_pkg::req_type req,
   output logic                   rsp_valid,
   output tsch_pkg::rsp_type      rsp,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data
);
   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIN} state_type;

   state_type state_ff;
   logic [7:0] mask_ff;
   logic [CW-1:0] count_ff, occ_ff, steps_ff;
   logic [1:0] op_ff;
   logic [2:0] id_ff;
   logic [tsch_pkg::TIME_W-1:0] s_ff, e_ff, now_ff;
   logic [7:0] run_ff;
   logic conflict_ff;
   logic rsp_valid_ff;
   tsch_pkg::rsp_type rsp_ff;

   tsch_pkg::entry_type cell_q [MAX_TASKS];
   tsch_pkg::cell_ctl_type cell_ctl [MAX_TASKS];
   tsch_pkg::entry_type load_data;
   tsch_pkg::entry_type head;

   logic keep, head_reg, in_window, overlap, add_ok, do_load;
   logic act_start, act_stop;
   logic [IW-1:0] load_idx;

   function automatic logic registered(input logic [2:0] id, input logic [7:0] m);
      registered = (32'(id) < 32'(NUM_OBJECTS)) && m[id];
   endfunction

   assign head = cell_q[0];
   assign keep = (op_ff != tsch_pkg::OP_REMOVE) || (head.obj != id_ff);
   assign head_reg = registered(head.obj, mask_ff);
   assign in_window = (now_ff >= head.start) && (now_ff <= head.stop);
   assign overlap = (head.obj == id_ff) &&
      (((s_ff >= head.start) && (s_ff <= head.stop)) ||
       ((e_ff >= head.start) && (e_ff <= head.stop)) ||
       ((s_ff < head.start) && (e_ff > head.stop)));
   assign add_ok = registered(id_ff, mask_ff) && (s_ff < e_ff) &&
      (32'(count_ff) < 32'(MAX_TASKS)) && !conflict_ff;
   // tick: running copy updates at once for later entries
   assign act_start = (op_ff == tsch_pkg::OP_TICK) && head_reg &&
      !run_ff[head.obj] && in_window;
   assign act_stop = (op_ff == tsch_pkg::OP_TICK) && head_reg &&
      run_ff[head.obj] && !in_window;

   // tail write: recycled head during a walk, new window on accepted add
   always_comb begin
      do_load = 1'b0;
      load_idx = IW'(occ_ff - CW'(1));
      load_data = head;
      if (state_ff == S_WALK) begin
         do_load = keep;
      end else if (state_ff == S_FIN && op_ff == tsch_pkg::OP_ADD && add_ok) begin
         do_load = 1'b1;
         load_idx = IW'(count_ff);
         load_data.obj = id_ff;
         load_data.start = s_ff;
         load_data.stop = e_ff;
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_TASKS; g++) begin : g_cell
         always_comb begin
            cell_ctl[g].shift = (state_ff == S_WALK);
            cell_ctl[g].load = do_load && (load_idx == IW'(g));
         end
         tsch_cell u_cell (
            .clock     (clock),
            .ctl       (cell_ctl[g]),
            .load_data (load_data),
            .next_data ((g + 1 < MAX_TASKS) ? cell_q[(g + 1) % MAX_TASKS] : cell_q[g]),
            .data      (cell_q[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mask_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (start) begin
                  op_ff <= req.opcode;
                  id_ff <= req.object_id;
                  s_ff <= tsch_pkg::minutes(req.start_hour, req.start_minute);
                  e_ff <= tsch_pkg::minutes(req.stop_hour, req.stop_minute);
                  now_ff <= tsch_pkg::minutes(req.now_hour, req.now_minute);
                  run_ff <= req.running_mask;
                  conflict_ff <= 1'b0;
                  occ_ff <= count_ff;
                  steps_ff <= count_ff;
                  if (req.opcode == tsch_pkg::OP_CLEAR || count_ff == '0) begin
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_WALK;
                  end
               end
            end
            S_WALK: begin
               if (!keep) begin
                  occ_ff <= occ_ff - CW'(1);
               end
               if (op_ff == tsch_pkg::OP_ADD && overlap) begin
                  conflict_ff <= 1'b1;
               end
               rsp_valid_ff <= act_start || act_stop;
               rsp_ff.kind <= act_start ? tsch_pkg::KIND_START : tsch_pkg::KIND_STOP;
               rsp_ff.object_id_out <= head.obj;
               rsp_ff.last <= 1'b0;
               if (act_start) begin
                  run_ff[head.obj] <= 1'b1;
               end else if (act_stop) begin
                  run_ff[head.obj] <= 1'b0;
               end
               steps_ff <= steps_ff - CW'(1);
               if (steps_ff == CW'(1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.object_id_out <= 3'd0;
               rsp_ff.last <= 1'b1;
               case (op_ff)
                  tsch_pkg::OP_ADD: begin
                     rsp_ff.kind <= add_ok ? tsch_pkg::KIND_ACCEPT : tsch_pkg::KIND_REJECT;
                     if (add_ok) begin
                        count_ff <= count_ff + CW'(1);
                     end
                  end
                  tsch_pkg::OP_REMOVE: begin
                     rsp_ff.kind <= tsch_pkg::KIND_DONE;
                     count_ff <= occ_ff;
                  end
                  tsch_pkg::OP_CLEAR: begin
                     rsp_ff.kind <= tsch_pkg::KIND_DONE;
                     count_ff <= '0;
                  end
                  default: rsp_ff.kind <= tsch_pkg::KIND_DONE;
               endcase
               state_ff <= S_IDLE;
            end
            default: begin
               rsp_valid_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_TASKS)) else $error("entry count beyond capacity");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.last) |-> (state_ff == S_IDLE)) else $error("last result while busy");
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (occ_ff <= count_ff && steps_ff != '0))
      else $error("walk occupancy out of range");
   a_walk_only_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.last) |-> $past(state_ff == S_WALK && op_ff == tsch_pkg::OP_TICK))
      else $error("start or stop outside a tick walk");
endmodule
`default_nettype wire
